// File: rtl/lrts_pkg.sv
package lrts_pkg;

  localparam int MAX_PROCS = 16;
  localparam int TIME_BITS = 16;

  localparam int SLOT_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int FLD_W  = 16;
  localparam int ID_W   = 8;
  // Common width for comparing clock values against 16-bit fields
  localparam int XW     = (TIME_BITS > FLD_W) ? TIME_BITS : FLD_W;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [FLD_W-1:0] arrival;
    logic [FLD_W-1:0] burst;
    logic [FLD_W-1:0] remain;
  } slot_entry_t;

  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
    slot_entry_t       entry;
  } pick_cand_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    slot_entry_t       entry;
  } pick_result_t;

  function automatic logic [XW-1:0] sat_sub(input logic [XW-1:0] a, input logic [XW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

// File: rtl/lrts_in_if.sv
interface lrts_in_if;
  import lrts_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [ID_W-1:0]  process_id;
  logic [FLD_W-1:0] arrival_time;
  logic [FLD_W-1:0] burst_time;

  modport source(output valid, func, process_id, arrival_time, burst_time, input ready);
  modport sink(input valid, func, process_id, arrival_time, burst_time, output ready);
endinterface

// File: rtl/lrts_out_if.sv
interface lrts_out_if;
  import lrts_pkg::*;

  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  running_id;
  logic             idle;
  logic [FLD_W-1:0] time_after;
  logic             finished;
  logic [FLD_W-1:0] wait_ticks;
  logic [FLD_W-1:0] turnaround_ticks;
  logic             all_done;

  modport source(output valid, running_id, idle, time_after, finished, wait_ticks,
                 turnaround_ticks, all_done, input ready);
  modport sink(input valid, running_id, idle, time_after, finished, wait_ticks,
               turnaround_ticks, all_done, output ready);
endinterface

// File: rtl/lrts_pick.sv
module lrts_pick (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clear,
  input  lrts_pkg::pick_cand_t   cand,
  input  logic [lrts_pkg::TIME_BITS-1:0] now,
  output lrts_pkg::pick_result_t result
);
  import lrts_pkg::*;

  logic              found_r;
  logic [SLOT_W-1:0] slot_r;
  slot_entry_t       entry_r;
  logic              take;

  // Strictly greater keeps the lowest slot on a tie; best starts at zero
  assign take = cand.vld
             && (XW'(cand.entry.arrival) <= XW'(now))
             && (cand.entry.remain != '0)
             && (!found_r || (cand.entry.remain > entry_r.remain));

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot_r  <= cand.slot;
      entry_r <= cand.entry;
    end
  end

  assign result.found = found_r;
  assign result.slot  = slot_r;
  assign result.entry = entry_r;
endmodule

// File: rtl/longest_remaining_time_scheduler_top.sv
// Load transaction: written straight into the slot table while there is a free slot, no result.
// Tick transaction: the slot table is scanned, the picked slot written back and the result
// registered; the single read port of the slot table is walked one slot per cycle, and no new
// transaction is taken until the result has been placed in the result register.
// Reset (synchronous, active low) clears slot count, done count, time and the sequencer;
// the slot table itself is not cleared, only slots below the slot count are ever used.
module longest_remaining_time_scheduler_top (
  input  logic clk,
  input  logic rst_n,
  lrts_in_if.sink    in_ch,
  lrts_out_if.source out_ch
);
  import lrts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  state_t state_r;

  // Slot table: one write port, one registered read port
  slot_entry_t mem [MAX_PROCS];
  slot_entry_t rd_data_r;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_entry_t       wr_data;

  logic [CNT_W-1:0]     slot_count_r;
  logic [CNT_W-1:0]     done_count_r;
  logic [TIME_BITS-1:0] now_r;
  logic [CNT_W-1:0]     idx_r;
  logic              rd_vld_r;
  logic [SLOT_W-1:0] rd_slot_r;

  // Per-tick outcome, held between update and emit
  logic             tk_idle_r;
  logic             tk_fin_r;
  logic [ID_W-1:0]  tk_id_r;
  logic [XW-1:0]    tk_turn_r;
  logic [FLD_W-1:0] tk_burst_r;

  // Result register
  logic             out_valid_r;
  logic [ID_W-1:0]  out_id_r;
  logic             out_idle_r;
  logic [FLD_W-1:0] out_time_r;
  logic             out_fin_r;
  logic [FLD_W-1:0] out_wait_r;
  logic [FLD_W-1:0] out_turn_r;
  logic             out_done_r;

  logic in_fire;
  logic load_ok;
  logic scan_more;
  pick_cand_t   cand;
  pick_result_t pick;

  logic [TIME_BITS-1:0] now_inc;
  logic [FLD_W-1:0]     rem_dec;
  logic                 fin_now;
  logic [XW-1:0]        turn_now;
  logic [XW-1:0]        wait_now;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign load_ok     = in_fire && (in_ch.func == FUNC_LOAD) && (slot_count_r < CNT_W'(MAX_PROCS));
  assign scan_more   = (idx_r < slot_count_r);

  // Time saturates at the top of its range; work still runs
  assign now_inc  = (now_r == TIME_MAX) ? now_r : now_r + 1'b1;
  assign rem_dec  = pick.entry.remain - 1'b1;
  assign fin_now  = pick.found && (rem_dec == '0);
  assign turn_now = sat_sub(XW'(now_inc), XW'(pick.entry.arrival));
  assign wait_now = sat_sub(tk_turn_r, XW'(tk_burst_r));

  // Write port: loads in idle, write-back of the picked slot in update.
  // Read data is used only while scanning, so no write can overlap a read in use.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_count_r[SLOT_W-1:0];
    wr_data = pick.entry;
    if (state_r == ST_IDLE) begin
      wr_en          = load_ok;
      wr_data.id      = in_ch.process_id;
      wr_data.arrival = in_ch.arrival_time;
      wr_data.burst   = in_ch.burst_time;
      wr_data.remain  = in_ch.burst_time;
    end else if (state_r == ST_UPDATE) begin
      wr_en          = pick.found;
      wr_addr        = pick.slot;
      wr_data.remain = rem_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[idx_r[SLOT_W-1:0]];
  end

  assign cand.vld   = rd_vld_r;
  assign cand.slot  = rd_slot_r;
  assign cand.entry = rd_data_r;

  lrts_pick u_pick (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (in_fire && (in_ch.func == FUNC_TICK)),
    .cand   (cand),
    .now    (now_r),
    .result (pick)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_count_r <= '0;
      done_count_r <= '0;
      now_r        <= '0;
      idx_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // Drop the taken result; in emit the result register is refilled instead
      if (out_valid_r && out_ch.ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          idx_r    <= '0;
          rd_vld_r <= 1'b0;
          if (load_ok) begin
            slot_count_r <= slot_count_r + 1'b1;
            // Zero burst counts as finished at once and never runs
            if (in_ch.burst_time == '0) begin
              done_count_r <= done_count_r + 1'b1;
            end
          end
          if (in_fire && (in_ch.func == FUNC_TICK)) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle; the picker sees the registered read data on the next cycle
          rd_vld_r  <= scan_more;
          rd_slot_r <= idx_r[SLOT_W-1:0];
          if (scan_more) begin
            idx_r <= idx_r + 1'b1;
          end else if (!rd_vld_r) begin
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          now_r      <= now_inc;
          tk_idle_r  <= !pick.found;
          tk_fin_r   <= fin_now;
          tk_id_r    <= pick.found ? pick.entry.id : '0;
          tk_turn_r  <= turn_now;
          tk_burst_r <= pick.entry.burst;
          if (fin_now) begin
            done_count_r <= done_count_r + 1'b1;
          end
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          // Hold until the result register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_id_r    <= tk_id_r;
            out_idle_r  <= tk_idle_r;
            out_time_r  <= FLD_W'(XW'(now_r));
            out_fin_r   <= tk_fin_r;
            out_wait_r  <= tk_fin_r ? FLD_W'(wait_now) : '0;
            out_turn_r  <= tk_fin_r ? FLD_W'(tk_turn_r) : '0;
            out_done_r  <= (done_count_r == slot_count_r);
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.running_id       = out_id_r;
  assign out_ch.idle             = out_idle_r;
  assign out_ch.time_after       = out_time_r;
  assign out_ch.finished         = out_fin_r;
  assign out_ch.wait_ticks       = out_wait_r;
  assign out_ch.turnaround_ticks = out_turn_r;
  assign out_ch.all_done         = out_done_r;
endmodule

// File: rtl/lrts_check.sv
module lrts_check (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_func,
  input logic out_valid,
  input logic out_ready,
  input logic [lrts_pkg::ID_W-1:0] out_running_id,
  input logic out_idle,
  input logic out_finished
);
  import lrts_pkg::*;

  // A pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // A load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_LOAD) && !out_valid |=> !out_valid)
    else $error("load transaction produced a result");

  // A tick occupies the scheduler: no new transaction next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_TICK) |=> !in_ready)
    else $error("input taken while a tick is in flight");

  // An idle tick runs nothing and finishes nothing
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_idle |-> (out_running_id == '0) && !out_finished)
    else $error("idle tick reports a running process");
endmodule

bind longest_remaining_time_scheduler_top lrts_check u_lrts_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_func        (in_ch.func),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_running_id (out_ch.running_id),
  .out_idle       (out_ch.idle),
  .out_finished   (out_ch.finished)
);
